FILE: design/gtg_pkg.sv
// shared types, widths and constants of the go-to-goal drive controller
// no dependencies; imported by every module of the block
package gtg_pkg;

  // number of cordic micro-rotations (8..24)
  localparam int CORDIC_ITERATIONS = 16;
  // restoring square root, one result bit per step; also the length of the
  // shared iteration phase, so it must not be below CORDIC_ITERATIONS
  localparam int ISQRT_STEPS = 25;
  localparam int CNT_W = 5;

  localparam int POS_W   = 24;
  localparam int DIFF_W  = 25;
  localparam int SQ_W    = 2 * POS_W;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int RAD_W   = 2 * ISQRT_STEPS;
  localparam int ROOT_W  = ISQRT_STEPS;
  localparam int REM_W   = ROOT_W + 2;
  localparam int XY_W    = 44;
  localparam int ANG_W   = 46;
  localparam int ANG_FRAC = 40;
  localparam int CORDIC_PRESCALE = 16;
  localparam int HDG_W   = 16;
  localparam int HEADING_SHIFT = ANG_FRAC - 13;
  localparam int MAG_W   = 15;
  localparam int CMD_W   = 16;
  localparam int TIMER_W = 21;
  localparam int ELAPSED_W = 16;
  localparam int TURN_SHIFT = 11;
  localparam int TURN_ROUND = 1024;

  // configuration register widths
  localparam int HDB_W  = 15;
  localparam int DDB_W  = 16;
  localparam int GAIN_W = 16;
  localparam int TLIM_W = 15;
  localparam int FLIM_W = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // angles in Q40 radians
  localparam logic signed [ANG_W-1:0] PI_Q40     = 46'sd3454217652356;
  localparam logic signed [ANG_W-1:0] NEG_PI_Q40 = -46'sd3454217652356;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q40 = 46'sd6908435304712;
  localparam logic signed [ANG_W-1:0] ROUND_HALF = 46'sd67108864;

  // command codes
  localparam logic [1:0] CMD_SET_GOAL = 2'd0;
  localparam logic [1:0] CMD_POSE     = 2'd1;
  localparam logic [1:0] CMD_MOVE     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_DB  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_DB = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_LIMIT   = 3'd4;

  // control of the cordic unit from the sequencer
  typedef struct packed {
    logic             start;
    logic             step;
    logic [CNT_W-1:0] idx;
  } gtg_cordic_ctl_t;

  // atan(2^-i) in Q40, truncated power series terms
  function automatic logic signed [ANG_W-1:0] atan_q40(input logic [CNT_W-1:0] idx);
    case (idx)
      5'd0:    atan_q40 = 46'sd863554413089;
      5'd1:    atan_q40 = 46'sd509785937287;
      5'd2:    atan_q40 = 46'sd269356888664;
      5'd3:    atan_q40 = 46'sd136729762477;
      5'd4:    atan_q40 = 46'sd68630207382;
      5'd5:    atan_q40 = 46'sd34348560107;
      5'd6:    atan_q40 = 46'sd17178471287;
      5'd7:    atan_q40 = 46'sd8589759836;
      5'd8:    atan_q40 = 46'sd4294945451;
      5'd9:    atan_q40 = 46'sd2147480918;
      5'd10:   atan_q40 = 46'sd1073741483;
      5'd11:   atan_q40 = 46'sd536870870;
      5'd12:   atan_q40 = 46'sd268435451;
      // series has a single term from here on
      default: atan_q40 = ANG_W'(1) << (ANG_FRAC - int'(idx));
    endcase
  endfunction

endpackage

FILE: design/go_to_goal_drive_controller.sv
// top level of the go-to-goal drive controller: sequencer, state, config
// depends on gtg_pkg, gtg_cordic, gtg_isqrt
//
// Turn-then-drive rover controller. Transactions on the input channel set the
// goal (cmd 0), report a pose (cmd 1) or load a timed manual move (cmd 2);
// cmd 3 is dropped. A pose produces one velocity command transaction on the
// output channel; a manual move with a positive duration produces one at
// once; goal updates produce none. While the manual timer is positive a pose
// returns the manual velocities, counts the timer down and moves the goal to
// the pose. Otherwise the goal distance (exact floor square root, saturated
// to 24 bits) and the bearing (16-step cordic) are computed; beyond the
// distance deadband the rover turns in place with gain times the heading
// error, clamped to turn_limit, or drives at forward_limit once the error is
// inside the heading deadband. The first pose after reset also becomes the
// goal. An automatic pose goes from acceptance through the squares of the
// offsets, the 25 steps of the square root with the cordic alongside, the
// error wrap, the rounding, the gain multiply and the clamp to the result
// register. in_stall is high for the whole time a pose is being worked on.
// A finished result sits in the output register and the next transaction
// can be taken meanwhile.
// Configuration writes must only be issued while the block is idle.
module go_to_goal_drive_controller import gtg_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic signed [POS_W-1:0]     in_pos_x,
  input  logic signed [POS_W-1:0]     in_pos_y,
  input  logic signed [HDG_W-1:0]     in_heading,
  input  logic [ELAPSED_W-1:0]        in_elapsed_ms,
  input  logic signed [CMD_W-1:0]     in_move_linear,
  input  logic signed [CMD_W-1:0]     in_move_angular,
  input  logic signed [TIMER_W-1:0]   in_move_duration_ms,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [CMD_W-1:0]     out_drive_linear,
  output logic signed [CMD_W-1:0]     out_drive_angular,
  output logic [POS_W-1:0]            out_goal_distance,
  output logic                        out_manual_mode,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SUM, S_ITER, S_ERR, S_WRAP, S_RND, S_GAIN, S_CMD, S_DONE
  } state_t;

  // control state
  state_t                     state_r, state_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [POS_W-1:0]    goal_x_r, goal_x_nxt, goal_y_r, goal_y_nxt;
  logic                       first_pose_r, first_pose_nxt;
  logic signed [TIMER_W-1:0]  timer_r, timer_nxt;
  logic signed [CMD_W-1:0]    man_lin_r, man_lin_nxt, man_ang_r, man_ang_nxt;
  logic [HDB_W-1:0]           hdg_db_r, hdg_db_nxt;
  logic [DDB_W-1:0]           dist_db_r, dist_db_nxt;
  logic [GAIN_W-1:0]          gain_r, gain_nxt;
  logic [TLIM_W-1:0]          turn_lim_r, turn_lim_nxt;
  logic [FLIM_W-1:0]          fwd_lim_r, fwd_lim_nxt;

  // datapath
  logic signed [DIFF_W-1:0]   dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [HDG_W-1:0]    heading_r, heading_nxt;
  logic [PROD_W-1:0]          prod_r, prod_nxt;
  logic [SQ_W-1:0]            sq_r, sq_nxt;
  logic [POS_W-1:0]           dist_r, dist_nxt;
  logic signed [ANG_W-1:0]    e_r, e_nxt;
  logic [MAG_W-1:0]           mag_r, mag_nxt;
  logic                       err_neg_r, err_neg_nxt;
  logic signed [CMD_W-1:0]    res_lin_r, res_lin_nxt, res_ang_r, res_ang_nxt;
  logic [POS_W-1:0]           res_dist_r, res_dist_nxt;
  logic                       res_man_r, res_man_nxt;
  logic signed [CMD_W-1:0]    out_lin_r, out_lin_nxt, out_ang_r, out_ang_nxt;
  logic [POS_W-1:0]           out_dist_r, out_dist_nxt;
  logic                       out_man_r, out_man_nxt;

  // shared multiplier and helpers
  logic signed [DIFF_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic                       in_acc;
  logic signed [TIMER_W:0]    timer_sub;
  logic [RAD_W-1:0]           rad;
  logic [ROOT_W-1:0]          root;
  logic signed [ANG_W-1:0]    bearing, e_rnd;
  logic [HDG_W-1:0]           err_q, mag_full;
  logic [PROD_W-1:0]          turn_sum;
  logic [PROD_W-TURN_SHIFT-1:0] turn_q;
  logic [TLIM_W-1:0]          turn_mag;
  logic                       isqrt_start, isqrt_step;
  gtg_cordic_ctl_t            cordic_ctl;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign mul_p = mul_a * mul_b;
  assign rad   = RAD_W'(sq_r) + RAD_W'(prod_r[SQ_W-1:0]);

  // manual timer countdown, saturating at the most negative value
  assign timer_sub = (TIMER_W+1)'(timer_r)
                   - (TIMER_W+1)'(signed'({1'b0, in_elapsed_ms}));

  // heading error rounding to 2^-13 rad
  assign e_rnd    = e_r + ROUND_HALF;
  assign err_q    = e_rnd[HEADING_SHIFT +: HDG_W];
  assign mag_full = err_q[HDG_W-1] ? -err_q : err_q;

  // turn rate magnitude: (gain * |err| + 1024) >> 11, clamped
  assign turn_sum = prod_r + PROD_W'(TURN_ROUND);
  assign turn_q   = turn_sum[PROD_W-1:TURN_SHIFT];
  assign turn_mag = (turn_q > (PROD_W-TURN_SHIFT)'(turn_lim_r)) ? turn_lim_r
                                                                : turn_q[TLIM_W-1:0];

  // shared iteration phase drives both units
  assign isqrt_start      = (state_r == S_SUM);
  assign isqrt_step       = (state_r == S_ITER);
  assign cordic_ctl.start = (state_r == S_SUM);
  assign cordic_ctl.step  = (state_r == S_ITER) && (cnt_r < CNT_W'(CORDIC_ITERATIONS));
  assign cordic_ctl.idx   = cnt_r;

  gtg_isqrt u_isqrt (
    .clk   (clk),
    .start (isqrt_start),
    .step  (isqrt_step),
    .rad   (rad),
    .root  (root)
  );

  gtg_cordic u_cordic (
    .clk   (clk),
    .ctl   (cordic_ctl),
    .dx    (dx_r),
    .dy    (dy_r),
    .angle (bearing)
  );

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    cnt_nxt        = cnt_r;
    goal_x_nxt     = goal_x_r;
    goal_y_nxt     = goal_y_r;
    first_pose_nxt = first_pose_r;
    timer_nxt      = timer_r;
    man_lin_nxt    = man_lin_r;
    man_ang_nxt    = man_ang_r;
    hdg_db_nxt     = hdg_db_r;
    dist_db_nxt    = dist_db_r;
    gain_nxt       = gain_r;
    turn_lim_nxt   = turn_lim_r;
    fwd_lim_nxt    = fwd_lim_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    heading_nxt    = heading_r;
    prod_nxt       = prod_r;
    sq_nxt         = sq_r;
    dist_nxt       = dist_r;
    e_nxt          = e_r;
    mag_nxt        = mag_r;
    err_neg_nxt    = err_neg_r;
    res_lin_nxt    = res_lin_r;
    res_ang_nxt    = res_ang_r;
    res_dist_nxt   = res_dist_r;
    res_man_nxt    = res_man_r;
    out_lin_nxt    = out_lin_r;
    out_ang_nxt    = out_ang_r;
    out_dist_nxt   = out_dist_r;
    out_man_nxt    = out_man_r;
    mul_a          = dx_r;
    mul_b          = dx_r;

    // the user must issue config writes only while idle; the block does not enforce it
    if (cfg_we) begin
      case (cfg_index)
        REG_HEADING_DB:  hdg_db_nxt   = cfg_wdata[HDB_W-1:0];
        REG_DISTANCE_DB: dist_db_nxt  = cfg_wdata[DDB_W-1:0];
        REG_TURN_GAIN:   gain_nxt     = cfg_wdata[GAIN_W-1:0];
        REG_TURN_LIMIT:  turn_lim_nxt = cfg_wdata[TLIM_W-1:0];
        REG_FWD_LIMIT:   fwd_lim_nxt  = cfg_wdata[FLIM_W-1:0];
        default: ;
      endcase
    end

    // result register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_SET_GOAL: begin
              goal_x_nxt = in_pos_x;
              goal_y_nxt = in_pos_y;
            end
            CMD_POSE: begin
              first_pose_nxt = 1'b0;
              if (!timer_r[TIMER_W-1] && (timer_r != '0)) begin
                // manual move still running
                if (timer_sub[TIMER_W] != timer_sub[TIMER_W-1]) begin
                  timer_nxt = {1'b1, {(TIMER_W-1){1'b0}}};
                end else begin
                  timer_nxt = timer_sub[TIMER_W-1:0];
                end
                goal_x_nxt   = in_pos_x;
                goal_y_nxt   = in_pos_y;
                res_lin_nxt  = man_lin_r;
                res_ang_nxt  = man_ang_r;
                res_dist_nxt = '0;
                res_man_nxt  = 1'b1;
                state_nxt    = S_DONE;
              end else begin
                dx_nxt      = DIFF_W'(goal_x_r) - DIFF_W'(in_pos_x);
                dy_nxt      = DIFF_W'(goal_y_r) - DIFF_W'(in_pos_y);
                heading_nxt = in_heading;
                // first pose seeds the goal; the offsets above use the old goal
                if (first_pose_r) begin
                  goal_x_nxt = in_pos_x;
                  goal_y_nxt = in_pos_y;
                end
                state_nxt = S_SQX;
              end
            end
            CMD_MOVE: begin
              timer_nxt   = in_move_duration_ms;
              man_lin_nxt = in_move_linear;
              man_ang_nxt = in_move_angular;
              if (!in_move_duration_ms[TIMER_W-1] && (in_move_duration_ms != '0)) begin
                res_lin_nxt  = in_move_linear;
                res_ang_nxt  = in_move_angular;
                res_dist_nxt = '0;
                res_man_nxt  = 1'b1;
                state_nxt    = S_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      S_SQX: begin
        mul_a     = dx_r;
        mul_b     = dx_r;
        prod_nxt  = PROD_W'(mul_p);
        state_nxt = S_SQY;
      end
      S_SQY: begin
        mul_a     = dy_r;
        mul_b     = dy_r;
        sq_nxt    = prod_r[SQ_W-1:0];
        prod_nxt  = PROD_W'(mul_p);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        // square root and cordic load here
        cnt_nxt   = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ISQRT_STEPS - 1)) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        dist_nxt  = (|root[ROOT_W-1:POS_W]) ? '1 : root[POS_W-1:0];
        e_nxt     = bearing - (ANG_W'(heading_r) <<< HEADING_SHIFT);
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        // bring the error into (-pi, pi]
        if (e_r > PI_Q40) begin
          e_nxt = e_r - TWO_PI_Q40;
        end else if (e_r <= NEG_PI_Q40) begin
          e_nxt = e_r + TWO_PI_Q40;
        end else begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        err_neg_nxt = err_q[HDG_W-1];
        mag_nxt     = mag_full[MAG_W-1:0];
        state_nxt   = S_GAIN;
      end
      S_GAIN: begin
        mul_a     = DIFF_W'(gain_r);
        mul_b     = DIFF_W'(mag_r);
        prod_nxt  = PROD_W'(mul_p);
        state_nxt = S_CMD;
      end
      S_CMD: begin
        res_lin_nxt  = '0;
        res_ang_nxt  = '0;
        res_dist_nxt = dist_r;
        res_man_nxt  = 1'b0;
        if (dist_r > POS_W'(dist_db_r)) begin
          if (mag_r > hdg_db_r) begin
            res_ang_nxt = err_neg_r ? -CMD_W'(turn_mag) : CMD_W'(turn_mag);
          end else begin
            res_lin_nxt = CMD_W'(fwd_lim_r);
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the result register to be free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_lin_nxt   = res_lin_r;
          out_ang_nxt   = res_ang_r;
          out_dist_nxt  = res_dist_r;
          out_man_nxt   = res_man_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    heading_r  <= heading_nxt;
    prod_r     <= prod_nxt;
    sq_r       <= sq_nxt;
    dist_r     <= dist_nxt;
    e_r        <= e_nxt;
    mag_r      <= mag_nxt;
    err_neg_r  <= err_neg_nxt;
    res_lin_r  <= res_lin_nxt;
    res_ang_r  <= res_ang_nxt;
    res_dist_r <= res_dist_nxt;
    res_man_r  <= res_man_nxt;
    out_lin_r  <= out_lin_nxt;
    out_ang_r  <= out_ang_nxt;
    out_dist_r <= out_dist_nxt;
    out_man_r  <= out_man_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      goal_x_r     <= '0;
      goal_y_r     <= '0;
      first_pose_r <= 1'b1;
      timer_r      <= '0;
      man_lin_r    <= '0;
      man_ang_r    <= '0;
      hdg_db_r     <= HDB_W'(1147);
      dist_db_r    <= DDB_W'(150);
      gain_r       <= GAIN_W'(512);
      turn_lim_r   <= TLIM_W'(410);
      fwd_lim_r    <= FLIM_W'(307);
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      goal_x_r     <= goal_x_nxt;
      goal_y_r     <= goal_y_nxt;
      first_pose_r <= first_pose_nxt;
      timer_r      <= timer_nxt;
      man_lin_r    <= man_lin_nxt;
      man_ang_r    <= man_ang_nxt;
      hdg_db_r     <= hdg_db_nxt;
      dist_db_r    <= dist_db_nxt;
      gain_r       <= gain_nxt;
      turn_lim_r   <= turn_lim_nxt;
      fwd_lim_r    <= fwd_lim_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_linear  = out_lin_r;
  assign out_drive_angular = out_ang_r;
  assign out_goal_distance = out_dist_r;
  assign out_manual_mode   = out_man_r;

endmodule

FILE: design/gtg_isqrt.sv
// restoring integer square root, one result bit per clock while step is high
// depends on gtg_pkg
module gtg_isqrt import gtg_pkg::*; (
  input  logic              clk,
  input  logic              start,
  input  logic              step,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  val_r, val_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt, rem_sh, trial;
  logic [ROOT_W-1:0] root_r, root_nxt;

  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], val_r[RAD_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      val_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (step) begin
      val_nxt = {val_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;

endmodule

FILE: design/gtg_cordic.sv
// vectoring cordic for atan2, one micro-rotation per clock while step is high
// depends on gtg_pkg (angle table, widths)
module gtg_cordic import gtg_pkg::*; (
  input  logic                     clk,
  input  gtg_cordic_ctl_t          ctl,
  input  logic signed [DIFF_W-1:0] dx,
  input  logic signed [DIFF_W-1:0] dy,
  output logic signed [ANG_W-1:0]  angle
);

  logic signed [XY_W-1:0]  x_r, y_r, x_nxt, y_nxt, x0, y0, xs, ys;
  logic signed [ANG_W-1:0] z_r, z_nxt, z0;
  logic                    y_pos;

  always_comb begin
    x0 = XY_W'(dx) <<< CORDIC_PRESCALE;
    y0 = XY_W'(dy) <<< CORDIC_PRESCALE;
    z0 = '0;
    // left half plane: rotate by pi first
    if (dx[DIFF_W-1]) begin
      x0 = -x0;
      y0 = -y0;
      z0 = dy[DIFF_W-1] ? NEG_PI_Q40 : PI_Q40;
    end
    xs    = x_r >>> ctl.idx;
    ys    = y_r >>> ctl.idx;
    y_pos = !y_r[XY_W-1] && (y_r != '0);
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (ctl.start) begin
      x_nxt = x0;
      y_nxt = y0;
      z_nxt = z0;
    end else if (ctl.step) begin
      if (y_pos) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_q40(ctl.idx);
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_q40(ctl.idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign angle = z_r;

endmodule

FILE: design/gtg_checker.sv
// port-level checks of the go-to-goal drive controller, bound to the top level
// depends on gtg_pkg and go_to_goal_drive_controller
module gtg_checker import gtg_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              in_cmd,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [CMD_W-1:0] out_drive_linear,
  input logic signed [CMD_W-1:0] out_drive_angular,
  input logic [POS_W-1:0]        out_goal_distance,
  input logic                    out_manual_mode
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_linear)
      && $stable(out_drive_angular) && $stable(out_goal_distance)
      && $stable(out_manual_mode))
    else $error("stalled result changed");

  // manual results carry no distance
  a_manual_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_manual_mode |-> out_goal_distance == '0)
    else $error("manual result with nonzero distance");

  // automatic mode either turns in place or drives forward, never both
  a_auto_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_manual_mode |->
      (out_drive_linear == '0 || out_drive_angular == '0) && !out_drive_linear[CMD_W-1])
    else $error("automatic command turns and drives at once");

  // a pose keeps the block busy for at least the following cycle
  a_pose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_POSE |=> in_stall)
    else $error("pose taken without going busy");

  // a goal update leaves the block ready and produces no result
  a_goal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_SET_GOAL |=> !in_stall && !$rose(out_valid))
    else $error("goal update produced a result or stalled");

endmodule

bind go_to_goal_drive_controller gtg_checker u_gtg_checker (.*);
